@@ rtl/htg_pkg.sv @@
// Shared types, constants and hash functions for the hash tag generator.
// No dependencies; used by every module under rtl/.
package htg_pkg;

   localparam logic [7:0] TAG_MARK   = 8'h23;   // '#'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CHAR_ALPHA = 8'h41;   // 'A'

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   // One accepted request word: absorb a byte or finish the message.
   typedef struct packed {
      logic       valid;
      logic       mode;
      logic [7:0] data;
   } req_word_type;

   // Mixed hash handed from the hash core to the tag emitter.
   typedef struct packed {
      logic        valid;
      logic [31:0] hash;
   } load_word_type;

   function automatic logic [31:0] absorb_byte(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + {{24{b[7]}}, b};
      t = t + (t << 10);
      t = t ^ (t >> 6);
      return t;
   endfunction

   function automatic logic [31:0] final_mix(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
   endfunction

   // Position of the highest nonzero nibble; zero for a zero hash.
   function automatic logic [2:0] top_nibble(input logic [31:0] h);
      logic [2:0] idx;
      idx = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (h[k*4 +: 4] != 4'd0) begin
            idx = 3'(k);
         end
      end
      return idx;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = CHAR_ALPHA + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

@@ rtl/htg_hash_core.sv @@
// Running one-at-a-time hash register: absorbs bytes, applies the final mix
// on finish and clears. Depends on htg_pkg.
module htg_hash_core (
   input  logic                  clock,
   input  logic                  reset,
   input  htg_pkg::req_word_type item,
   output htg_pkg::load_word_type load
);

   logic [31:0] hash_ff;
   logic [31:0] hash_in;

   always_comb begin
      hash_in = hash_ff;
      if (item.valid) begin
         if (item.mode == htg_pkg::MODE_FINISH) begin
            hash_in = 32'd0;
         end else begin
            hash_in = htg_pkg::absorb_byte(hash_ff, item.data);
         end
      end
   end

   assign load.valid = item.valid && (item.mode == htg_pkg::MODE_FINISH);
   assign load.hash  = htg_pkg::final_mix(hash_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= 32'd0;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

@@ rtl/htg_tag_emit.sv @@
// Tag emitter: holds one mixed hash and sends '#' and its hex digits, one
// word per cycle while rsp_stall is low, from registers. Depends on htg_pkg.
module htg_tag_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  htg_pkg::load_word_type load,
   output logic                   emit_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_tag_char,
   output logic                   rsp_last_char
);

   logic        busy_ff, busy_in;
   logic        hdr_ff, hdr_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] hash_ff, hash_in;
   logic        take;

   assign take = busy_ff && !rsp_stall;

   always_comb begin
      busy_in = busy_ff;
      hdr_in  = hdr_ff;
      pos_in  = pos_ff;
      hash_in = hash_ff;
      if (take) begin
         if (hdr_ff) begin
            hdr_in = 1'b0;
         end else if (pos_ff == 3'd0) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff - 3'd1;
         end
      end
      if (load.valid) begin
         busy_in = 1'b1;
         hdr_in  = 1'b1;
         hash_in = load.hash;
         pos_in  = htg_pkg::top_nibble(load.hash);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hdr_ff  <= 1'b0;
         pos_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         hdr_ff  <= hdr_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   // Free now, or the last word leaves this cycle.
   assign emit_free = !busy_ff || (take && !hdr_ff && (pos_ff == 3'd0));

   assign rsp_valid     = busy_ff;
   assign rsp_tag_char  = hdr_ff ? htg_pkg::TAG_MARK
                                 : htg_pkg::hex_char(hash_ff[{pos_ff, 2'b00} +: 4]);
   assign rsp_last_char = !hdr_ff && (pos_ff == 3'd0);

endmodule

@@ rtl/hash_tag_generator.sv @@
// Hash tag generator top level: input register, hash core and tag emitter.
// Depends on htg_pkg, htg_hash_core and htg_tag_emit.
//
// Each absorb word folds one byte into the running hash, so bytes stream in at
// one per cycle while no finish waits in the input register. A finish word
// hands the mixed hash to the tag emitter, which sends '#' and then 1 to 8 hex
// digits, one word per cycle while rsp_stall is low, the last one marked. Bytes
// of the next message keep flowing in while a tag is sent; a second finish
// waits in the input register until the emitter's single tag register is free.
module hash_tag_generator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tag_char,
   output logic       rsp_last_char
);

   htg_pkg::req_word_type  in_ff, in_in;
   htg_pkg::req_word_type  item;
   htg_pkg::load_word_type load;
   logic                   emit_free;
   logic                   stage_go;
   logic                   req_take;

   // A finish may leave the input register only when the emitter can load it.
   assign stage_go  = (in_ff.mode == htg_pkg::MODE_ABSORB) || emit_free;
   assign req_stall = in_ff.valid && !stage_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_in = in_ff;
      if (req_take) begin
         in_in.valid = 1'b1;
         in_in.mode  = req_mode;
         in_in.data  = req_data_byte;
      end else if (stage_go) begin
         in_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else begin
         in_ff.valid <= in_in.valid;
      end
      in_ff.mode <= in_in.mode;
      in_ff.data <= in_in.data;
   end

   always_comb begin
      item       = in_ff;
      item.valid = in_ff.valid && stage_go;
   end

   htg_hash_core u_hash (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .load  (load)
   );

   htg_tag_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .emit_free     (emit_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tag_char  (rsp_tag_char),
      .rsp_last_char (rsp_last_char)
   );

   a_stall_on_finish: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_ff.valid && (in_ff.mode == htg_pkg::MODE_FINISH)))
      else $error("input stalled without a pending finish");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> (!rsp_valid || (!rsp_stall && rsp_last_char)))
      else $error("tag loaded over a tag still being sent");

   a_mark_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> (rsp_tag_char != htg_pkg::TAG_MARK))
      else $error("tag ended on its mark character");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_char && !load.valid) |=> !rsp_valid)
      else $error("result word sent after the last character");

endmodule

@@ dv/hash_tag_generator_test.sv @@
// Self-checking testbench for hash_tag_generator: streams message bytes and finish
// words, predicts each '#'-prefixed hex tag and checks every tag character.
// Depends on htg_pkg and the hash_tag_generator RTL.
module hash_tag_generator_test;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] tag_char;
      logic       last_char;
   } tag_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = htg_pkg::MODE_ABSORB;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tag_char;
   logic       rsp_last_char;

   req_item_type pending_words[$];
   tag_word_type expected_chars[$];
   logic [31:0]  msg_hash = 32'd0;
   int           words_sent = 0;
   int           chars_checked = 0;
   int           tags_queued = 0;
   int           mismatches = 0;
   logic         quiet_stretch;
   req_item_type next_word;
   tag_word_type want;

   hash_tag_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tag_char  (rsp_tag_char),
      .rsp_last_char (rsp_last_char)
   );

   always #6 clock = ~clock;

   // No idling on either side while this window of words goes through.
   assign quiet_stretch = (words_sent >= 120) && (words_sent < 200);

   function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] t;
      t = h + 32'($signed(b));
      t = t + (t << 10);
      return t ^ (t >> 6);
   endfunction

   function automatic logic [31:0] mix_hash(input logic [31:0] h);
      logic [31:0] t;
      t = h + (h << 3);
      t = t ^ (t >> 11);
      return t + (t << 15);
   endfunction

   // Number of hex digits in the tag, leading zeros dropped.
   function automatic int tag_digits(input logic [31:0] h);
      int n;
      n = 1;
      for (int k = 7; k > 0; k--) begin
         if (n == 1 && (h >> (4 * k)) != 32'd0) begin
            n = k + 1;
         end
      end
      return n;
   endfunction

   task automatic fold_or_emit(input logic mode, input logic [7:0] b);
      logic [31:0]  mixed;
      logic [3:0]   nib;
      tag_word_type w;
      int           n;
      if (mode == htg_pkg::MODE_ABSORB) begin
         msg_hash = fold_byte(msg_hash, b);
      end else begin
         mixed = mix_hash(msg_hash);
         msg_hash = 32'd0;
         n = tag_digits(mixed);
         w.tag_char = htg_pkg::TAG_MARK;
         w.last_char = 1'b0;
         expected_chars.push_back(w);
         for (int k = n - 1; k >= 0; k--) begin
            nib = mixed[4 * k +: 4];
            w.tag_char = (nib < 4'd10) ? htg_pkg::CHAR_ZERO + 8'(nib)
                                       : htg_pkg::CHAR_ALPHA + 8'(nib) - 8'd10;
            w.last_char = (k == 0);
            expected_chars.push_back(w);
         end
      end
   endtask

   task automatic queue_word(input logic mode, input logic [7:0] b);
      req_item_type w;
      w.mode = mode;
      w.data_byte = b;
      pending_words.push_back(w);
      if (mode == htg_pkg::MODE_FINISH) begin
         tags_queued++;
      end
   endtask

   // Driver: hold the word while stalled, otherwise advance or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_or_emit(req_mode, req_data_byte);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && (quiet_stretch || $urandom_range(99) >= 31)) begin
               next_word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_mode <= next_word.mode;
               req_data_byte <= next_word.data_byte;
            end else begin
               req_valid <= 1'b0;
               req_mode <= 1'($urandom);
               req_data_byte <= 8'($urandom);
            end
         end
      end
   end

   // Monitor: stall at random and check each accepted tag word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_stretch && ($urandom_range(99) < 31);
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("tag_char: expected no word, got %h (last_char %b)",
                      rsp_tag_char, rsp_last_char);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               chars_checked++;
               if (rsp_tag_char !== want.tag_char) begin
                  $error("tag_char: expected %h, got %h", want.tag_char, rsp_tag_char);
                  mismatches++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %b, got %b", want.last_char, rsp_last_char);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      logic [15:0] short_msg[1:7];
      bit          short_found[1:7];
      logic [7:0]  edge_bytes[4];
      int          n;
      int          len;
      int          pick;

      edge_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
      for (int d = 1; d <= 7; d++) begin
         short_found[d] = 1'b0;
      end
      // Find two-byte messages whose tags come out shorter than eight digits.
      for (int a = 0; a < 256; a++) begin
         for (int b = 0; b < 256; b++) begin
            n = tag_digits(mix_hash(fold_byte(fold_byte(32'd0, 8'(a)), 8'(b))));
            if (n < 8 && !short_found[n]) begin
               short_found[n] = 1'b1;
               short_msg[n] = {8'(a), 8'(b)};
            end
         end
      end

      // Directed: empty message, zero-byte message (mixed hash of zero),
      // byte extremes, back-to-back finishes, short tags.
      queue_word(htg_pkg::MODE_FINISH, 8'hA5);
      queue_word(htg_pkg::MODE_ABSORB, 8'h00);
      queue_word(htg_pkg::MODE_FINISH, 8'h00);
      for (int i = 0; i < 4; i++) begin
         queue_word(htg_pkg::MODE_ABSORB, edge_bytes[i]);
      end
      queue_word(htg_pkg::MODE_FINISH, 8'hFF);
      queue_word(htg_pkg::MODE_FINISH, 8'h5A);
      queue_word(htg_pkg::MODE_ABSORB, 8'h00);
      queue_word(htg_pkg::MODE_ABSORB, 8'h00);
      queue_word(htg_pkg::MODE_FINISH, 8'h00);
      for (int d = 1; d <= 7; d++) begin
         if (short_found[d]) begin
            queue_word(htg_pkg::MODE_ABSORB, short_msg[d][15:8]);
            queue_word(htg_pkg::MODE_ABSORB, short_msg[d][7:0]);
            queue_word(htg_pkg::MODE_FINISH, 8'($urandom));
         end
      end

      // Random messages, mostly short, some long, some empty.
      while (pending_words.size() < 330) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            len = 0;
         end else if (pick < 85) begin
            len = $urandom_range(8, 1);
         end else begin
            len = $urandom_range(40, 9);
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) begin
               queue_word(htg_pkg::MODE_ABSORB, edge_bytes[$urandom_range(3)]);
            end else begin
               queue_word(htg_pkg::MODE_ABSORB, 8'($urandom));
            end
         end
         queue_word(htg_pkg::MODE_FINISH, 8'($urandom));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray tag word show up.
      repeat (30) @(posedge clock);

      $display("Sent %0d request words forming %0d messages; checked %0d tag characters.",
               words_sent, tags_queued, chars_checked);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(12 * 200000);
      $display("Timeout waiting for tag words");
      $display("Some tests failed");
      $finish;
   end

endmodule
